FILE: rtl/ppt_pkg.sv
// Package for the point-in-polygon test unit.
// Holds coordinate widths, the edge class codes and the queued edge item type.
// No dependencies.
package ppt_pkg;

	localparam int COORD_BITS = 32;
	localparam int FIELD_W    = 32;
	localparam int CW         = COORD_BITS;
	localparam int DW         = CW + 1;
	localparam int PW         = 2 * DW;
	localparam int SW         = PW + 1;
	localparam int QDEPTH     = 4;
	localparam int QIDX_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	typedef enum logic {
		REG_QUERY_X = 1'b0,
		REG_QUERY_Y = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLS_NONE = 2'd0,
		CLS_FLIP = 2'd1,
		CLS_PROD = 2'd2
	} edge_cls_t;

	typedef struct packed {
		logic                 start;
		logic                 last;
		edge_cls_t            cls;
		logic                 dy_neg;
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
		logic signed [DW-1:0] c;
		logic signed [DW-1:0] d;
	} edge_op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// low COORD_BITS bits of a field, taken as a signed coordinate
	function automatic logic signed [CW-1:0] to_coord(input logic [FIELD_W-1:0] v);
		logic [63:0] t;
		t = 64'(v);
		return t[CW-1:0];
	endfunction

endpackage

FILE: rtl/point_in_polygon_test_unit.sv
// Top level of the point-in-polygon test unit.
// Instantiates ppt_front, ppt_queue and ppt_back; holds the query registers.
//
// Takes one polygon vertex per cycle while the queue is not full. Each vertex
// forms an edge with the one before it; the edge is classified at entry and
// queued (four entries), then the back end forms the two products, takes the
// sign of their sum and folds the toggle into the crossing parity. The result
// for a last vertex is registered after the queue, the product stage and the sign
// stage, and is held while results are stalled; the queue lets the vertex side
// keep accepting for four items while a result is held. The query point is
// written through the cfg port (index 0: x, index 1: y), which is always ready.
module point_in_polygon_test_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [ppt_pkg::FIELD_W-1:0]        cfg_data,
	input  logic                               vertex_valid,
	output logic                               vertex_stall,
	input  logic signed [ppt_pkg::FIELD_W-1:0] vertex_x,
	input  logic signed [ppt_pkg::FIELD_W-1:0] vertex_y,
	input  logic                               first_vertex,
	input  logic                               last_vertex,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               inside_res
);

	logic [ppt_pkg::FIELD_W-1:0] query_x_q, query_y_q;
	logic                        push, pop;
	ppt_pkg::edge_op_t           push_op, head_op;
	ppt_pkg::q_status_t          q_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q <= '0;
			query_y_q <= '0;
		end else if (cfg_valid) begin
			unique case (ppt_pkg::reg_idx_t'(cfg_index))
				ppt_pkg::REG_QUERY_X: query_x_q <= cfg_data;
				ppt_pkg::REG_QUERY_Y: query_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ppt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.first_vertex (first_vertex),
		.last_vertex  (last_vertex),
		.query_x      (query_x_q),
		.query_y      (query_y_q),
		.q_status     (q_status),
		.push         (push),
		.push_op      (push_op)
	);

	ppt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.status  (q_status)
	);

	ppt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_op      (head_op),
		.q_status     (q_status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.inside_res   (inside_res)
	);

endmodule

FILE: rtl/ppt_front.sv
// Front end: accepts vertices, forms edges and classifies them.
// Writes one edge item per vertex into the queue. Depends on ppt_pkg.
module ppt_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vertex_valid,
	output logic                        vertex_stall,
	input  logic signed [ppt_pkg::FIELD_W-1:0] vertex_x,
	input  logic signed [ppt_pkg::FIELD_W-1:0] vertex_y,
	input  logic                        first_vertex,
	input  logic                        last_vertex,
	input  logic [ppt_pkg::FIELD_W-1:0] query_x,
	input  logic [ppt_pkg::FIELD_W-1:0] query_y,
	input  ppt_pkg::q_status_t          q_status,
	output logic                        push,
	output ppt_pkg::edge_op_t           push_op
);

	logic signed [ppt_pkg::CW-1:0] prev_x_q, prev_y_q;
	logic                          have_prev_q;
	logic signed [ppt_pkg::CW-1:0] cx, cy, qx, qy;
	logic signed [ppt_pkg::DW-1:0] dy;
	logic                          start;

	assign vertex_stall = q_status.full;
	assign push         = vertex_valid & ~q_status.full;

	assign cx    = ppt_pkg::to_coord(vertex_x);
	assign cy    = ppt_pkg::to_coord(vertex_y);
	assign qx    = ppt_pkg::to_coord(query_x);
	assign qy    = ppt_pkg::to_coord(query_y);
	assign dy    = ppt_pkg::DW'(cy) - ppt_pkg::DW'(prev_y_q);
	assign start = first_vertex | ~have_prev_q;

	always_comb begin
		push_op.start  = start;
		push_op.last   = last_vertex;
		push_op.dy_neg = dy[ppt_pkg::DW-1];
		push_op.a      = ppt_pkg::DW'(cx) - ppt_pkg::DW'(qx);
		push_op.b      = dy;
		push_op.c      = ppt_pkg::DW'(cx) - ppt_pkg::DW'(prev_x_q);
		push_op.d      = ppt_pkg::DW'(qy) - ppt_pkg::DW'(cy);
		push_op.cls    = ppt_pkg::CLS_NONE;
		if (start || dy == '0) begin
			push_op.cls = ppt_pkg::CLS_NONE;
		end else if (cy == qy) begin
			if (cx > qx && dy < 0)
				push_op.cls = ppt_pkg::CLS_FLIP;
		end else if (prev_y_q == qy) begin
			if (prev_x_q > qx && dy > 0)
				push_op.cls = ppt_pkg::CLS_FLIP;
		end else if ((cy > qy) != (prev_y_q > qy)) begin
			push_op.cls = ppt_pkg::CLS_PROD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (push) begin
			have_prev_q <= ~last_vertex;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			prev_x_q <= cx;
			prev_y_q <= cy;
		end
	end

endmodule

FILE: rtl/ppt_queue.sv
// Short queue of edge items between the front and back ends.
// Register array with head/tail pointers. Depends on ppt_pkg.
module ppt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ppt_pkg::edge_op_t  push_op,
	input  logic               pop,
	output ppt_pkg::edge_op_t  head_op,
	output ppt_pkg::q_status_t status
);

	ppt_pkg::edge_op_t              mem_q [ppt_pkg::QDEPTH];
	logic [ppt_pkg::QIDX_W-1:0]     wr_q, rd_q;
	logic [ppt_pkg::QCNT_W-1:0]     cnt_q;

	assign status.full  = (cnt_q == ppt_pkg::QCNT_W'(ppt_pkg::QDEPTH));
	assign status.empty = (cnt_q == '0);
	assign head_op      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == ppt_pkg::QIDX_W'(ppt_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == ppt_pkg::QIDX_W'(ppt_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_op;
	end

endmodule

FILE: rtl/ppt_back.sv
// Back end: product stage, sign stage, parity accumulation and result register.
// Drains edge items from the queue in order. Depends on ppt_pkg.
module ppt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ppt_pkg::edge_op_t  head_op,
	input  ppt_pkg::q_status_t q_status,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               inside_res
);

	logic                          adv;
	logic                          valid_s1, start_s1, last_s1, dy_neg_s1;
	ppt_pkg::edge_cls_t            cls_s1;
	logic signed [ppt_pkg::PW-1:0] p1_s1, p2_s1;
	logic                          valid_s2, start_s2, last_s2, tog_s2;
	logic signed [ppt_pkg::SW-1:0] sum;
	logic                          tog;
	logic                          par_next;
	logic                          parity_q, valid_q, inside_q;

	assign adv = ~valid_q | ~result_stall;
	assign pop = adv & ~q_status.empty;

	assign sum = ppt_pkg::SW'(p1_s1) + ppt_pkg::SW'(p2_s1);

	always_comb begin
		case (cls_s1)
			ppt_pkg::CLS_FLIP: tog = 1'b1;
			ppt_pkg::CLS_PROD: tog = (sum != '0) && (sum[ppt_pkg::SW-1] == dy_neg_s1);
			default:           tog = 1'b0;
		endcase
	end

	assign par_next = (start_s2 ? 1'b0 : parity_q) ^ tog_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
			parity_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2 & last_s2;
			if (valid_s2)
				parity_q <= last_s2 ? 1'b0 : par_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			start_s1  <= head_op.start;
			last_s1   <= head_op.last;
			cls_s1    <= head_op.cls;
			dy_neg_s1 <= head_op.dy_neg;
			p1_s1     <= head_op.a * head_op.b;
			p2_s1     <= head_op.c * head_op.d;
			start_s2  <= start_s1;
			last_s2   <= last_s1;
			tog_s2    <= tog;
			inside_q  <= par_next;
		end
	end

	assign result_valid = valid_q;
	assign inside_res   = inside_q;

endmodule

FILE: rtl/ppt_checker.sv
// Port-level checker for the point-in-polygon test unit, with its bind.
// Watches only the top-level ports. Depends on ppt_pkg.
module ppt_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic                               cfg_index,
	input logic [ppt_pkg::FIELD_W-1:0]        cfg_data,
	input logic                               vertex_valid,
	input logic                               vertex_stall,
	input logic signed [ppt_pkg::FIELD_W-1:0] vertex_x,
	input logic signed [ppt_pkg::FIELD_W-1:0] vertex_y,
	input logic                               first_vertex,
	input logic                               last_vertex,
	input logic                               result_valid,
	input logic                               result_stall,
	input logic                               inside_res
);

	logic [3:0] pending_q;
	logic       last_in, res_out;

	assign last_in = vertex_valid & ~vertex_stall & last_vertex;
	assign res_out = result_valid & ~result_stall;

	// polygons closed but not yet reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({last_in, res_out})
				2'b10:   pending_q <= pending_q + 1'b1;
				2'b01:   pending_q <= pending_q - 1'b1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(inside_res))
		else $error("stalled result changed");

	a_result_owed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != '0)
		else $error("result without a closed polygon");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write not taken");

endmodule

bind point_in_polygon_test_unit ppt_checker u_chk (.*);
